// ----- sv/ssbr_pkg.sv -----
// Shared types and constants for the symmetric separable row blur.
// Used by ssbr_gamma and symmetric_separable_blur_row; no dependencies.
package ssbr_pkg;

  // Default sizes
  localparam int MAX_RADIUS   = 31;
  localparam int CHANNEL_BITS = 24;
  localparam int WEIGHT_BITS  = 16;

  // Fixed point: one is 1 << FRAC_BITS
  localparam int FRAC_BITS = 12;

  // Row pixel counter, saturating
  localparam int SEEN_W = 7;

  // Register word indexes (byte address 4*i)
  localparam logic [1:0] REG_EXTEND_BOUNDS = 2'd0;
  localparam logic [1:0] REG_GAMMA_IN      = 2'd1;
  localparam logic [1:0] REG_GAMMA_OUT     = 2'd2;
  localparam logic [1:0] REG_RADIUS        = 2'd3;

  // Input item kinds
  localparam logic ACT_WEIGHT = 1'b0;
  localparam logic ACT_PIXEL  = 1'b1;

  // Gamma unit operation
  typedef enum logic {
    GOP_SQUARE = 1'b0,
    GOP_ROOT   = 1'b1
  } gamma_op_e;

  typedef struct packed {
    logic      start;
    gamma_op_e op;
  } gamma_req_t;

endpackage

// ----- sv/ssbr_gamma.sv -----
// Iterative gamma unit: one multiply, then a restoring divide (C*C/A') or a
// digit-by-digit square root (sqrt(C*A')), one bit per cycle. Uses ssbr_pkg.
module ssbr_gamma #(
  parameter int CHANNEL_BITS = ssbr_pkg::CHANNEL_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ssbr_pkg::gamma_req_t           req_i,
  input  logic signed [CHANNEL_BITS-1:0] c_i,
  input  logic signed [CHANNEL_BITS-1:0] a_i,
  output logic                           done_o,
  output logic signed [CHANNEL_BITS-1:0] res_o,
  output logic                           sat_o
);

  localparam int MAG_W = CHANNEL_BITS - 1;
  localparam int DEN_W = (MAG_W > ssbr_pkg::FRAC_BITS + 1) ? MAG_W : ssbr_pkg::FRAC_BITS + 1;
  localparam int PW    = MAG_W + DEN_W;
  localparam int SQ_W  = (PW + 1) / 2;
  localparam int SR_W  = SQ_W + 2;
  localparam int CNT_W = $clog2(SQ_W + 1);

  typedef enum logic [4:0] {
    G_IDLE = 5'b00001,
    G_MUL  = 5'b00010,
    G_PREP = 5'b00100,
    G_ITER = 5'b01000,
    G_DONE = 5'b10000
  } gstate_e;

  gstate_e              state_q, state_d;
  ssbr_pkg::gamma_op_e  op_q;
  logic [MAG_W-1:0]     opa_q;
  logic [DEN_W-1:0]     opb_q;
  logic [DEN_W-1:0]     den_q;
  logic [PW-1:0]        prod_q;
  logic [DEN_W-1:0]     div_rem_q;
  logic [MAG_W-1:0]     div_bits_q;
  logic [MAG_W-1:0]     quo_q;
  logic [SR_W-1:0]      sq_rem_q;
  logic [2*SQ_W-1:0]    sq_bits_q;
  logic [SQ_W-1:0]      root_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [MAG_W-1:0]     res_q;
  logic                 sat_q;

  logic                 c_pos;
  logic [DEN_W-1:0]     a_eff;
  logic [DEN_W:0]       div_try;
  logic                 div_ge;
  logic [DEN_W:0]       div_diff;
  logic [SR_W+1:0]      sq_try;
  logic [SR_W+1:0]      sq_trial;
  logic                 sq_ge;
  logic [SR_W+1:0]      sq_diff;
  logic [SQ_W:0]        root_ext;
  logic [DEN_W-1:0]     prod_hi;

  // Alpha at or below zero counts as one
  assign c_pos = !c_i[CHANNEL_BITS-1] && (c_i != '0);
  assign a_eff = (!a_i[CHANNEL_BITS-1] && (a_i != '0)) ? DEN_W'(a_i[MAG_W-1:0])
                                                     : (DEN_W'(1) << ssbr_pkg::FRAC_BITS);

  // Divide step
  assign div_try  = {div_rem_q, div_bits_q[MAG_W-1]};
  assign div_ge   = div_try >= {1'b0, den_q};
  assign div_diff = div_try - {1'b0, den_q};

  // Square root step
  assign sq_try   = {sq_rem_q, sq_bits_q[2*SQ_W-1 -: 2]};
  assign sq_trial = (SR_W + 2)'({root_q, 2'b01});
  assign sq_ge    = sq_try >= sq_trial;
  assign sq_diff  = sq_try - sq_trial;
  assign root_ext = {1'b0, root_q};
  assign prod_hi  = prod_q[PW-1:MAG_W];

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      G_IDLE: if (req_i.start) state_d = c_pos ? G_MUL : G_DONE;
      G_MUL:  state_d = G_PREP;
      G_PREP: begin
        if (op_q == ssbr_pkg::GOP_SQUARE && prod_hi >= den_q) state_d = G_DONE;
        else state_d = G_ITER;
      end
      G_ITER: if (cnt_q == CNT_W'(1)) state_d = G_DONE;
      G_DONE: state_d = G_IDLE;
      default: state_d = G_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      G_IDLE: begin
        op_q  <= req_i.op;
        opa_q <= c_i[MAG_W-1:0];
        opb_q <= (req_i.op == ssbr_pkg::GOP_SQUARE) ? DEN_W'(c_i[MAG_W-1:0]) : a_eff;
        den_q <= a_eff;
        res_q <= '0;
        sat_q <= 1'b0;
        // Keep a non-positive colour at zero when it skips the iterations
        cnt_q <= '1;
      end
      G_MUL: prod_q <= PW'(opa_q * opb_q);
      G_PREP: begin
        div_rem_q  <= prod_hi;
        div_bits_q <= prod_q[MAG_W-1:0];
        quo_q      <= '0;
        sq_rem_q   <= '0;
        sq_bits_q  <= (2 * SQ_W)'(prod_q);
        root_q     <= '0;
        if (op_q == ssbr_pkg::GOP_SQUARE) begin
          cnt_q <= CNT_W'(MAG_W);
          res_q <= '1;
        end else begin
          cnt_q <= CNT_W'(SQ_W);
        end
      end
      G_ITER: begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (op_q == ssbr_pkg::GOP_SQUARE) begin
          div_rem_q  <= div_ge ? div_diff[DEN_W-1:0] : div_try[DEN_W-1:0];
          div_bits_q <= div_bits_q << 1;
          quo_q      <= {quo_q[MAG_W-2:0], div_ge};
        end else begin
          sq_rem_q  <= sq_ge ? sq_diff[SR_W-1:0] : sq_try[SR_W-1:0];
          sq_bits_q <= sq_bits_q << 2;
          root_q    <= {root_q[SQ_W-2:0], sq_ge};
        end
      end
      G_DONE: begin
        if (op_q == ssbr_pkg::GOP_SQUARE) begin
          if (cnt_q == '0) res_q <= quo_q;
        end else if (cnt_q == '0) begin
          // Clip the root to the channel maximum
          if ((root_ext >> MAG_W) != '0) begin
            res_q <= '1;
            sat_q <= 1'b1;
          end else begin
            res_q <= root_q[MAG_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  // Result is valid during G_DONE except for iterated ops, which write it
  // there; done is registered from G_DONE so it pulses with the settled result
  logic done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == G_DONE);
    end
  end

  assign done_o = done_q;
  assign res_o  = {1'b0, res_q};
  assign sat_o  = sat_q;

endmodule

// ----- sv/symmetric_separable_blur_row.sv -----
// Flow: a weight is written while idle. A pixel passes load, check and next, plus, with
// gamma_in, the gamma unit per colour channel; each result passes the tap pipeline plus,
// with gamma_out, the gamma unit per colour channel; each flushed position passes check
// and next as well. Output stalls hold the sequencer in the emit state.
// Throughput: one item at a time; the sequencer, its four tap multipliers and the shared
// gamma unit set the rate. A row end flushes up to 2*radius positions before the next item.
// Reset: asynchronous, clears configuration, weights, counters and the output valid flag.
module symmetric_separable_blur_row #(
  parameter int MAX_RADIUS   = ssbr_pkg::MAX_RADIUS,
  parameter int CHANNEL_BITS = ssbr_pkg::CHANNEL_BITS,
  parameter int WEIGHT_BITS  = ssbr_pkg::WEIGHT_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic [4:0]                     weight_index_i,
  input  logic [WEIGHT_BITS-1:0]         weight_value_i,
  input  logic signed [CHANNEL_BITS-1:0] red_i,
  input  logic signed [CHANNEL_BITS-1:0] green_i,
  input  logic signed [CHANNEL_BITS-1:0] blue_i,
  input  logic signed [CHANNEL_BITS-1:0] alpha_i,
  input  logic                           row_end_i,
  // Output channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [CHANNEL_BITS-1:0] out_red_o,
  output logic signed [CHANNEL_BITS-1:0] out_green_o,
  output logic signed [CHANNEL_BITS-1:0] out_blue_o,
  output logic signed [CHANNEL_BITS-1:0] out_alpha_o,
  output logic                           row_last_o,
  output logic                           saturated_o,
  // Configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int CW     = CHANNEL_BITS;
  localparam int WB     = WEIGHT_BITS;
  localparam int WIN    = 2 * MAX_RADIUS + 1;
  localparam int POS_W  = $clog2(WIN);
  localparam int SH_W   = $clog2(WIN + 1);
  localparam int RW     = $clog2(MAX_RADIUS + 1);
  localparam int PRD_W  = CW + WB + 2;
  localparam int ACC_W  = PRD_W + $clog2(MAX_RADIUS + 2);
  localparam int SEEN_W = ssbr_pkg::SEEN_W;

  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(64'd1 << (WB - 1));
  localparam logic signed [ACC_W-1:0] CH_MAX = ACC_W'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] CH_MIN = ~CH_MAX;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_GIN    = 12'b000000000010,
    S_GIN_W  = 12'b000000000100,
    S_LOAD   = 12'b000000001000,
    S_CHECK  = 12'b000000010000,
    S_MAC    = 12'b000000100000,
    S_DRAIN  = 12'b000001000000,
    S_ROUND  = 12'b000010000000,
    S_GOUT   = 12'b000100000000,
    S_GOUT_W = 12'b001000000000,
    S_EMIT   = 12'b010000000000,
    S_NEXT   = 12'b100000000000
  } state_e;

  typedef logic signed [CW-1:0] chan_t;

  // Configuration registers
  logic           ext_q, gin_q, gout_q;
  logic [4:0]     radius_q;
  logic           cfg_wr;

  // Control state
  state_e              state_q, state_d;
  logic [SEEN_W-1:0]   seen_q;
  logic [SH_W-1:0]     shifts_q;
  logic [POS_W-1:0]    head_q;
  logic [POS_W-1:0]    k_q;
  logic [RW-1:0]       tap_q;
  logic [1:0]          ch_q;
  logic                last_q;
  logic                p1_v_q, p2_v_q;

  // Payload
  logic [WB-1:0]       kw_q [MAX_RADIUS+1];
  chan_t               px_q [4];
  chan_t               fill_q [4];
  chan_t               v_q [4];
  logic                flag_q;
  logic [4*CW-1:0]     win_mem [2**POS_W];
  logic [4*CW-1:0]     mem_a_q, mem_b_q;
  logic                p1_center_q, p1_real_a_q, p1_real_b_q;
  logic [WB-1:0]       p1_w_q;
  logic signed [PRD_W-1:0] prod_q [4];
  logic signed [ACC_W-1:0] acc_q [4];

  // Output register
  logic                out_valid_q;
  chan_t               out_q [4];
  logic                row_last_q, sat_out_q;

  // Combinational helpers
  logic [RW-1:0]       r_eff;
  logic [POS_W-1:0]    kmax;
  logic                emit_ok;
  logic [POS_W-1:0]    pos_a, pos_b;
  logic                in_xfer, out_xfer, emit_go;
  logic                mem_we;
  logic [4*CW-1:0]     mem_wdata;
  chan_t               samp_a [4];
  chan_t               samp_b [4];
  logic signed [CW:0]  samp_sum [4];
  logic signed [ACC_W-1:0] rnd_val [4];
  logic signed [ACC_W-1:0] shf_val [4];
  chan_t               rnd_sat [4];
  logic [3:0]          rnd_clip;

  ssbr_pkg::gamma_req_t g_req;
  chan_t               g_c, g_a, g_res;
  logic                g_done, g_sat;

  // ---------------------------------------------------------------------------
  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q    <= 1'b0;
      gin_q    <= 1'b0;
      gout_q   <= 1'b0;
      radius_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        ssbr_pkg::REG_EXTEND_BOUNDS: ext_q    <= pwdata[0];
        ssbr_pkg::REG_GAMMA_IN:      gin_q    <= pwdata[0];
        ssbr_pkg::REG_GAMMA_OUT:     gout_q   <= pwdata[0];
        ssbr_pkg::REG_RADIUS:        radius_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ssbr_pkg::REG_EXTEND_BOUNDS: prdata = 32'(ext_q);
      ssbr_pkg::REG_GAMMA_IN:      prdata = 32'(gin_q);
      ssbr_pkg::REG_GAMMA_OUT:     prdata = 32'(gout_q);
      ssbr_pkg::REG_RADIUS:        prdata = 32'(radius_q);
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Derived control
  assign r_eff    = (radius_q > 5'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_q);
  assign kmax     = ext_q ? (POS_W'(r_eff) << 1) : POS_W'(r_eff);
  assign emit_ok  = ext_q || ((8'(seen_q) + 8'(k_q)) >= (8'(r_eff) + 8'd1));
  assign pos_a    = POS_W'(r_eff) - POS_W'(tap_q);
  assign pos_b    = POS_W'(r_eff) + POS_W'(tap_q);
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_q && out_ready_i;
  assign emit_go  = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == S_IDLE);

  // Window write: a new pixel, or a flush pixel at row end
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = {px_q[3], px_q[2], px_q[1], px_q[0]};
    if (state_q == S_LOAD) begin
      mem_we = 1'b1;
    end else if (state_q == S_NEXT && last_q && k_q != kmax) begin
      mem_we = 1'b1;
      if (ext_q) mem_wdata = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && action_i == ssbr_pkg::ACT_PIXEL) state_d = gin_q ? S_GIN : S_LOAD;
      end
      S_GIN:   state_d = S_GIN_W;
      S_GIN_W: if (g_done) state_d = (ch_q == 2'd2) ? S_LOAD : S_GIN;
      S_LOAD:  state_d = S_CHECK;
      S_CHECK: state_d = emit_ok ? S_MAC : S_NEXT;
      S_MAC:   if (tap_q == r_eff) state_d = S_DRAIN;
      S_DRAIN: if (!p1_v_q && !p2_v_q) state_d = S_ROUND;
      S_ROUND: state_d = gout_q ? S_GOUT : S_EMIT;
      S_GOUT:  state_d = S_GOUT_W;
      S_GOUT_W: if (g_done) state_d = (ch_q == 2'd2) ? S_EMIT : S_GOUT;
      S_EMIT:  if (emit_go) state_d = S_NEXT;
      S_NEXT: begin
        if (!last_q || k_q == kmax) state_d = S_IDLE;
        else state_d = S_CHECK;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seen_q      <= '0;
      shifts_q    <= '0;
      head_q      <= '0;
      k_q         <= '0;
      tap_q       <= '0;
      ch_q        <= '0;
      last_q      <= 1'b0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int j = 0; j <= MAX_RADIUS; j++) kw_q[j] <= '0;
    end else begin
      state_q <= state_d;
      p1_v_q  <= (state_q == S_MAC);
      p2_v_q  <= p1_v_q;
      if (emit_go) out_valid_q <= 1'b1;
      else if (out_xfer) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          ch_q <= '0;
          if (in_xfer) begin
            if (action_i == ssbr_pkg::ACT_WEIGHT) begin
              if (weight_index_i <= 5'(MAX_RADIUS)) kw_q[weight_index_i[RW-1:0]] <= weight_value_i;
            end else begin
              last_q <= row_end_i;
            end
          end
        end
        S_GIN_W: if (g_done) ch_q <= ch_q + 2'd1;
        S_LOAD: begin
          head_q <= head_q + POS_W'(1);
          k_q    <= '0;
          if (seen_q == '0) shifts_q <= SH_W'(1);
          else if (shifts_q != SH_W'(WIN)) shifts_q <= shifts_q + SH_W'(1);
          if (seen_q != '1) seen_q <= seen_q + SEEN_W'(1);
        end
        S_CHECK: tap_q <= '0;
        S_MAC:   if (tap_q != r_eff) tap_q <= tap_q + RW'(1);
        S_ROUND: ch_q <= '0;
        S_GOUT_W: if (g_done) ch_q <= ch_q + 2'd1;
        S_NEXT: begin
          if (last_q) begin
            if (k_q == kmax) begin
              seen_q <= '0;
            end else begin
              k_q    <= k_q + POS_W'(1);
              head_q <= head_q + POS_W'(1);
              if (shifts_q != SH_W'(WIN)) shifts_q <= shifts_q + SH_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel capture, row-start fill and gamma write-back
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      px_q[0] <= red_i;
      px_q[1] <= green_i;
      px_q[2] <= blue_i;
      px_q[3] <= alpha_i;
    end else if (state_q == S_GIN_W && g_done) begin
      px_q[ch_q] <= g_res;
    end
    if (state_q == S_LOAD && seen_q == '0) begin
      for (int c = 0; c < 4; c++) fill_q[c] <= ext_q ? '0 : px_q[c];
    end
  end

  // Window memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) win_mem[head_q + POS_W'(1)] <= mem_wdata;
    mem_a_q <= win_mem[head_q - pos_a];
    mem_b_q <= win_mem[head_q - pos_b];
  end

  // Tap stage 1: side info alongside the memory read
  always_ff @(posedge clk_i) begin
    p1_center_q <= (tap_q == '0);
    p1_real_a_q <= SH_W'(pos_a) < shifts_q;
    p1_real_b_q <= SH_W'(pos_b) < shifts_q;
    p1_w_q      <= kw_q[tap_q];
  end

  // Tap stage 2: pair the mirrored samples and multiply
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      samp_a[c]   = p1_real_a_q ? chan_t'(mem_a_q[c*CW +: CW]) : fill_q[c];
      samp_b[c]   = p1_center_q ? '0
                  : (p1_real_b_q ? chan_t'(mem_b_q[c*CW +: CW]) : fill_q[c]);
      samp_sum[c] = (CW+1)'(samp_a[c]) + (CW+1)'(samp_b[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      prod_q[c] <= samp_sum[c] * $signed({1'b0, p1_w_q});
    end
  end

  // Tap stage 3: accumulate
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      if (state_q == S_CHECK) acc_q[c] <= '0;
      else if (p2_v_q) acc_q[c] <= acc_q[c] + ACC_W'(prod_q[c]);
    end
  end

  // Round half up, drop weight fraction, clip to channel range
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      rnd_val[c]  = acc_q[c] + RND;
      shf_val[c]  = rnd_val[c] >>> WB;
      rnd_clip[c] = (shf_val[c] > CH_MAX) || (shf_val[c] < CH_MIN);
      if (shf_val[c] > CH_MAX) rnd_sat[c] = CH_MAX[CW-1:0];
      else if (shf_val[c] < CH_MIN) rnd_sat[c] = CH_MIN[CW-1:0];
      else rnd_sat[c] = shf_val[c][CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_ROUND) begin
      for (int c = 0; c < 4; c++) v_q[c] <= rnd_sat[c];
      flag_q <= |rnd_clip;
    end else if (state_q == S_GOUT_W && g_done) begin
      v_q[ch_q] <= g_res;
      flag_q    <= flag_q | g_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared gamma unit
  assign g_req.start = (state_q == S_GIN) || (state_q == S_GOUT);
  assign g_req.op    = (state_q == S_GIN) ? ssbr_pkg::GOP_SQUARE : ssbr_pkg::GOP_ROOT;
  assign g_c         = (state_q == S_GIN) ? px_q[ch_q] : v_q[ch_q];
  assign g_a         = (state_q == S_GIN) ? px_q[3] : v_q[3];

  ssbr_gamma #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_gamma (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (g_req),
    .c_i    (g_c),
    .a_i    (g_a),
    .done_o (g_done),
    .res_o  (g_res),
    .sat_o  (g_sat)
  );

  // ---------------------------------------------------------------------------
  // Output register: load a finished result, hold until transfer
  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      for (int c = 0; c < 4; c++) out_q[c] <= v_q[c];
      row_last_q <= last_q && (k_q == kmax);
      sat_out_q  <= flag_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_q[0];
  assign out_green_o = out_q[1];
  assign out_blue_o  = out_q[2];
  assign out_alpha_o = out_q[3];
  assign row_last_o  = row_last_q;
  assign saturated_o = sat_out_q;

endmodule
